@@ rtl/tcc_pkg.sv @@
// shared types and constants of the text console cursor unit
package tcc_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [3:0] TAB_STOP     = 4'd8;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam int IN_W  = 72;
    localparam int OUT_W = 88;

    typedef struct packed {
        logic load_item;
        logic newline;
        logic emit_cell;
    } t_dp_cmd;

    typedef struct packed {
        logic in_newline;
        logic out_free;
        logic cnt_last;
    } t_dp_stat;

endpackage

@@ rtl/text_console_cursor_unit.sv @@
// top level of the text console cursor unit
// a newline moves the cursor and keeps the unit idle and ready; any other accepted
// character is held and the run state writes its draw transactions, one cell per cycle
// while the output is free, into the output register; a tab draws 1 to 8 cells, any
// other one; a stalled output holds the cell counter and with it the next accept
// reset: synchronous active low; cursor to 0,0, 80 columns, 25 rows, output empty
module text_console_cursor_unit import tcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // char_code[7:0], fg_color[39:8], bg_color[71:40]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // cell_col[7:0], cell_row[15:8], glyph_code[23:16], draw_fg[55:24], draw_bg[87:56]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_cell |-> stat.out_free)
        else $error("cell emitted into a full output register");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_item || cmd.newline) |-> (s_axis_tvalid && s_axis_tready))
        else $error("character loaded without an input transaction");

    a_newline_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && stat.in_newline) |=> s_axis_tready)
        else $error("newline left the unit busy");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !cmd.emit_cell)
        else $error("cell emitted while idle");
`endif

endmodule

@@ rtl/tcc_ctrl.sv @@
// control state machine: accepts characters and paces cell emission
module tcc_ctrl import tcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.in_newline) begin
                        o_cmd.newline = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_cell = 1'b1;
                    if (i_stat.cnt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tcc_dp.sv @@
// datapath: screen size, cursor, held character and output register
module tcc_dp import tcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic [IN_W-1:0]  i_in_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [OUT_W-1:0] o_out_data,
    output logic             o_out_last
);

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } t_pos;

    logic [7:0]  r_cols, r_rows;
    logic [7:0]  r_col, r_row;
    logic [7:0]  r_char;
    logic [31:0] r_fg, r_bg;
    logic [3:0]  r_cnt;
    logic        r_out_valid;
    logic [7:0]  r_out_col, r_out_row, r_out_glyph;
    logic [31:0] r_out_fg, r_out_bg;
    logic        r_out_last;

    logic [7:0]  eff_cols, eff_rows;
    logic        is_bs, is_tab;
    t_pos        cell_pos, wrap_pos, nl_pos;
    logic [8:0]  adv_col;
    logic [3:0]  load_cnt;

    function automatic t_pos wrap(input logic [8:0] col, input logic [7:0] row,
                                  input logic [7:0] ec, input logic [7:0] er);
        logic [8:0] c, r;
        t_pos       p;
        c = col;
        r = {1'b0, row};
        if (c >= {1'b0, ec}) begin
            c = 9'd0;
            r = r + 9'd1;
        end
        if (r >= {1'b0, er}) begin
            r = 9'd0;
        end
        p.col = c[7:0];
        p.row = r[7:0];
        return p;
    endfunction

    assign eff_cols = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign eff_rows = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign is_bs    = (r_char == CH_BACKSPACE);
    assign is_tab   = (r_char == CH_TAB);

    // backspace steps back before drawing, others draw at the cursor
    always_comb begin
        cell_pos.col = r_col;
        cell_pos.row = r_row;
        if (is_bs) begin
            if (r_col == 8'd0) begin
                cell_pos.col = eff_cols - 8'd1;
                cell_pos.row = (r_row == 8'd0) ? eff_rows - 8'd1 : r_row - 8'd1;
            end else begin
                cell_pos.col = r_col - 8'd1;
            end
        end
    end

    assign adv_col  = {1'b0, cell_pos.col} + {8'd0, !is_bs};
    assign wrap_pos = wrap(adv_col, cell_pos.row, eff_cols, eff_rows);
    assign nl_pos   = wrap({1'b0, eff_cols}, r_row, eff_cols, eff_rows);
    assign load_cnt = (i_in_data[7:0] == CH_TAB) ? TAB_STOP - {1'b0, r_col[2:0]} : 4'd1;

    assign o_stat.in_newline = (i_in_data[7:0] == CH_NEWLINE);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.cnt_last   = (r_cnt == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default:  r_cols <= r_cols;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else if (i_cmd.newline) begin
            r_col <= nl_pos.col;
            r_row <= nl_pos.row;
        end else if (i_cmd.emit_cell) begin
            r_col <= wrap_pos.col;
            r_row <= wrap_pos.row;
        end
    end

    // held character
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_char <= i_in_data[7:0];
            r_fg   <= i_in_data[39:8];
            r_bg   <= i_in_data[71:40];
            r_cnt  <= load_cnt;
        end else if (i_cmd.emit_cell) begin
            r_cnt  <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_cell) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cell) begin
            r_out_col   <= cell_pos.col;
            r_out_row   <= cell_pos.row;
            r_out_glyph <= (is_bs || is_tab) ? CH_SPACE : r_char;
            r_out_fg    <= r_fg;
            r_out_bg    <= r_bg;
            r_out_last  <= (r_cnt == 4'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_bg, r_out_fg, r_out_glyph, r_out_row, r_out_col};
    assign o_out_last  = r_out_last;

endmodule
